// ===== design/prvs_pkg.sv =====
// Package for the PCM rate-match volume scaler: widths, defaults, register
// indexes and the reciprocal used to divide by one hundred.
// No dependencies; every other file of the block imports it.
package prvs_pkg;

  // Field and register widths.
  localparam int unsigned SMP_IN_W   = 32;
  localparam int unsigned SMP_W      = 16;
  localparam int unsigned RATE_W     = 18;
  localparam int unsigned SUM_W      = 19;
  localparam int unsigned VOL_W      = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned CNT_W      = 3;

  // Rates and defaults.
  localparam int unsigned SINK_RATE_DEF       = 44100;
  localparam int unsigned MIN_SOURCE_RATE     = 8000;
  localparam int unsigned DEFAULT_SOURCE_RATE = 44100;
  localparam int unsigned DEFAULT_VOLUME      = 70;
  localparam int unsigned VOLUME_MAX          = 100;
  localparam int unsigned MAX_RESULTS         = 6;

  // Division by 100 as a multiplication by ceil(2^30 / 100); exact for
  // magnitudes below 2^22, which covers every sample times volume product.
  localparam int unsigned PROD_W      = SMP_W + VOL_W + 1;
  localparam int unsigned MAG_W       = 22;
  localparam int unsigned RECIP_W     = 24;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned RECIP_K     = 10737419;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_RATE   = 2'd0,
    CFG_CHANNEL_COUNT = 2'd1,
    CFG_VOLUME        = 2'd2,
    CFG_LINK_UP       = 2'd3
  } cfg_idx_e;

endpackage

// ===== design/prvs_if.sv =====
// Handshake interfaces for the frame input channel and the result output channel.
// Depends on prvs_pkg for the field widths.
interface prvs_frame_if;
  import prvs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SMP_IN_W-1:0] left_in;
  logic signed [SMP_IN_W-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface prvs_result_if;
  import prvs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] left_out;
  logic signed [SMP_W-1:0] right_out;
  logic                    last_of_run;

  modport source (output valid, output left_out, output right_out, output last_of_run,
                  input ready);
  modport sink (input valid, input left_out, input right_out, input last_of_run,
                output ready);
endinterface

// ===== design/prvs_lane.sv =====
// One scaling lane: sample times volume, divided by 100 toward zero, saturated.
// Three pipeline stages after capture; depends on prvs_pkg.
module prvs_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [prvs_pkg::SMP_W-1:0] sample_i,
  input  logic        [prvs_pkg::VOL_W-1:0] vol_i,
  output logic signed [prvs_pkg::SMP_W-1:0] result_o,
  output logic                              valid_o
);
  import prvs_pkg::*;

  localparam int unsigned QfW = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RecipK = RECIP_W'(RECIP_K);

  logic signed [SMP_W-1:0]  smp_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic [PROD_W-1:0]        abs_full;
  logic [MAG_W-1:0]         mag;
  logic [QfW-1:0]           qf_d, qf_q;
  logic                     neg_q;
  logic [SMP_W-1:0]         quo;
  logic signed [SMP_W:0]    sval;
  logic signed [SMP_W-1:0]  sat_d, res_q;
  logic [3:0]               vld_q;

  // Stage one: signed product of the sample and the volume.
  assign prod_d = PROD_W'(smp_q) * PROD_W'($signed({1'b0, vol_i}));

  // Stage two: magnitude times the reciprocal of one hundred.
  assign abs_full = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign mag      = abs_full[MAG_W-1:0];
  assign qf_d     = {{RECIP_W{1'b0}}, mag} * {{MAG_W{1'b0}}, RecipK};

  // Stage three: restore the sign and saturate to the 16-bit range.
  assign quo  = qf_q[QfW-1:RECIP_SHIFT];
  assign sval = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  always_comb begin
    if (sval > $signed((SMP_W+1)'(32767))) begin
      sat_d = SMP_W'(32767);
    end else if (sval < -$signed((SMP_W+1)'(32768))) begin
      sat_d = SMP_W'(-32768);
    end else begin
      sat_d = sval[SMP_W-1:0];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      smp_q <= sample_i;
    end
    prod_q <= prod_d;
    qf_q   <= qf_d;
    neg_q  <= prod_q[PROD_W-1];
    res_q  <= sat_d;
  end

  // Valid token follows the item through the capture and the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  assign result_o = res_q;
  assign valid_o  = vld_q[3];
endmodule

// ===== design/prvs_div.sv =====
// Restoring divider for the phase accumulator: one quotient bit per cycle.
// Gives the number of results due and the new accumulator; depends on prvs_pkg.
module prvs_div #(
  parameter int unsigned QUOT_W = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [prvs_pkg::SUM_W-1:0]   sum_i,
  input  logic [prvs_pkg::RATE_W-1:0]  rate_i,
  output logic                         done_o,
  output logic [QUOT_W-1:0]            quot_o,
  output logic [prvs_pkg::RATE_W-1:0]  rem_o
);
  import prvs_pkg::*;

  localparam int unsigned StepW  = $clog2(QUOT_W);
  localparam int unsigned TrialW = RATE_W + QUOT_W;

  logic [SUM_W-1:0]  rem_q;
  logic [RATE_W-1:0] rate_q;
  logic [QUOT_W-1:0] quot_q;
  logic [StepW-1:0]  step_q;
  logic              busy_q, done_q;
  logic [TrialW-1:0] trial, rem_ext, rem_sub;
  logic              fits;

  // Compare the remainder with the rate shifted to the current quotient bit.
  assign trial   = TrialW'(rate_q) << step_q;
  assign rem_ext = TrialW'(rem_q);
  assign fits    = rem_ext >= trial;
  assign rem_sub = rem_ext - trial;

  // Control: count the steps from the top quotient bit down.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(QUOT_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= sum_i;
      rate_q <= rate_i;
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_sub[SUM_W-1:0];
      end
      quot_q[step_q] <= fits;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[RATE_W-1:0];
endmodule

// ===== design/pcm_rate_match_volume_scaler_core.sv =====
// PCM rate-match volume scaler: phase accumulator, two scaling lanes, result merge.
// The run of results is emitted once the divider and both lanes are done; then one
// result a cycle while the output is ready. The divider's quotient width is 3 at the
// default sink rate. A new frame is taken only after the run of the last one has gone
// out; a frame taken while the link is down is dropped and the block stays ready.
// Reset is asynchronous, active low; it restores register defaults and clears the phase.
module pcm_rate_match_volume_scaler_core #(
  parameter int unsigned SINK_RATE = prvs_pkg::SINK_RATE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [prvs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [prvs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  prvs_frame_if.sink                          frame_i,
  prvs_result_if.source                       result_o
);
  import prvs_pkg::*;

  localparam int unsigned QuotW = $clog2(SINK_RATE / MIN_SOURCE_RATE + 2);
  localparam int unsigned QxW   = QuotW + CNT_W;

  typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_EMIT} state_e;

  state_e             state_q;
  logic [RATE_W-1:0]  rate_q, accum_q, rate_eff, rate_wr, div_rem;
  logic               mono_q, link_q, mono_wr;
  logic [VOL_W-1:0]   vol_q, vol_wr;
  logic [SUM_W-1:0]   sum;
  logic               accept, start;
  logic               div_done, div_seen_q, lane_seen_q, div_ok, lane_ok;
  logic [QuotW-1:0]   div_quot;
  logic [QxW-1:0]     quot_x;
  logic [CNT_W-1:0]   n_res, cnt_q;
  logic signed [SMP_W-1:0] left_smp, right_smp, left_res, right_res;
  logic signed [SMP_W-1:0] out_l_q, out_r_q;
  logic               left_vld, right_vld;

  // Handshake and start of work on a frame.
  assign frame_i.ready = (state_q == ST_IDLE);
  assign accept        = frame_i.valid && frame_i.ready;
  assign start         = accept && link_q;

  // Values that a configuration write would store.
  assign rate_wr  = (cfg_data_i == '0) ? RATE_W'(DEFAULT_SOURCE_RATE) : cfg_data_i[RATE_W-1:0];
  assign mono_wr  = (cfg_data_i[1:0] == 2'd1);
  assign vol_wr   = (cfg_data_i[VOL_W-1:0] > VOL_W'(VOLUME_MAX)) ? VOL_W'(VOLUME_MAX)
                                                                : cfg_data_i[VOL_W-1:0];
  assign rate_eff = (rate_q < RATE_W'(MIN_SOURCE_RATE)) ? RATE_W'(MIN_SOURCE_RATE) : rate_q;
  assign sum      = SUM_W'(accum_q) + SUM_W'(SINK_RATE);

  // Configuration registers and the phase accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= RATE_W'(DEFAULT_SOURCE_RATE);
      mono_q  <= 1'b0;
      vol_q   <= VOL_W'(DEFAULT_VOLUME);
      link_q  <= 1'b0;
      accum_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SOURCE_RATE: begin
          rate_q <= rate_wr;
          if (rate_wr != rate_q) begin
            accum_q <= '0;
          end
        end
        CFG_CHANNEL_COUNT: begin
          mono_q <= mono_wr;
          if (mono_wr != mono_q) begin
            accum_q <= '0;
          end
        end
        CFG_VOLUME:  vol_q  <= vol_wr;
        CFG_LINK_UP: link_q <= cfg_data_i[0];
        default: ;
      endcase
    end else if (state_q == ST_CALC && div_done) begin
      accum_q <= div_rem;
    end
  end

  // Phase divider: results due and the remainder.
  prvs_div #(
    .QUOT_W (QuotW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sum_i   (sum),
    .rate_i  (rate_eff),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // Two scaling lanes; in mono mode the left sample feeds both.
  assign left_smp  = frame_i.left_in[SMP_IN_W-1 -: SMP_W];
  assign right_smp = mono_q ? left_smp : frame_i.right_in[SMP_IN_W-1 -: SMP_W];

  prvs_lane u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .sample_i (left_smp),
    .vol_i    (vol_q),
    .result_o (left_res),
    .valid_o  (left_vld)
  );

  prvs_lane u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .sample_i (right_smp),
    .vol_i    (vol_q),
    .result_o (right_res),
    .valid_o  (right_vld)
  );

  // Number of results for this frame, capped at the per-frame limit.
  assign quot_x  = QxW'(div_quot);
  assign n_res   = (quot_x > QxW'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : quot_x[CNT_W-1:0];
  assign div_ok  = div_seen_q || div_done;
  assign lane_ok = lane_seen_q || (left_vld && right_vld);

  // Sequencer: wait for divider and lanes, then merge and emit the run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_seen_q  <= 1'b0;
      lane_seen_q <= 1'b0;
      cnt_q       <= '0;
      out_l_q     <= '0;
      out_r_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          div_seen_q  <= 1'b0;
          lane_seen_q <= 1'b0;
          if (start) begin
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          div_seen_q  <= div_ok;
          lane_seen_q <= lane_ok;
          if (div_ok && lane_ok) begin
            cnt_q   <= n_res;
            out_l_q <= left_res;
            out_r_q <= right_res;
            state_q <= (n_res == '0) ? ST_IDLE : ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (result_o.ready) begin
            if (cnt_q == CNT_W'(1)) begin
              state_q <= ST_IDLE;
            end else begin
              cnt_q <= cnt_q - 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_o.valid       = (state_q == ST_EMIT);
  assign result_o.left_out    = out_l_q;
  assign result_o.right_out   = out_r_q;
  assign result_o.last_of_run = (cnt_q == CNT_W'(1));
endmodule

// ===== design/prvs_checker.sv =====
// Port-level checker for the PCM rate-match volume scaler, bound to the top level.
// Depends on prvs_pkg and on the top level's ports.
module prvs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_we_i,
  input logic [prvs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input logic [prvs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [prvs_pkg::SMP_W-1:0]          out_left,
  input logic [prvs_pkg::SMP_W-1:0]          out_right,
  input logic                                out_last
);
  import prvs_pkg::*;

  logic link_sh_q;

  // Shadow of the link register, seen from the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_sh_q <= 1'b0;
    end else if (cfg_we_i && cfg_idx_i == CFG_LINK_UP) begin
      link_sh_q <= cfg_data_i[0];
    end
  end

  // A frame is never taken while a result of the previous one is on offer.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid))
    else $error("frame ready while a result is pending");

  // A frame taken with the link down is dropped and the block stays ready.
  a_link_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready && !link_sh_q) |=> in_ready)
    else $error("dropped frame did not leave the block ready");

  // A result that is not the last of its run is followed by another one.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && !out_last) |=> out_valid)
    else $error("run ended before its last result");

  // All results of one run carry the same samples.
  a_run_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && !out_last) |=> ($stable(out_left) && $stable(out_right)))
    else $error("samples changed within a run");

  // After the last result of a run the block takes frames again.
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("block not ready after the end of a run");
endmodule

bind pcm_rate_match_volume_scaler_core prvs_checker u_prvs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .cfg_we_i   (cfg_we_i),
  .cfg_idx_i  (cfg_idx_i),
  .cfg_data_i (cfg_data_i),
  .in_valid   (frame_i.valid),
  .in_ready   (frame_i.ready),
  .out_valid  (result_o.valid),
  .out_ready  (result_o.ready),
  .out_left   (result_o.left_out),
  .out_right  (result_o.right_out),
  .out_last   (result_o.last_of_run)
);
